/* hw/rtl/rks_pkg.sv */
// Shared constants, codes and control types for the range k-th smallest block.
`default_nettype none

package rks_pkg;

  // Default sizes
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths of the item and result ports
  localparam int unsigned POS_BITS    = 10;
  localparam int unsigned LEN_BITS    = 11;
  localparam int unsigned OUT_BITS    = 32;
  localparam int unsigned STATUS_BITS = 2;

  // Width used to compare positions against the effective length (DEPTH <= 65536)
  localparam int unsigned CMP_BITS = 18;

  localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD_POS  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_BAD_RANK = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_DONE
  } rks_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // take the input item (and do a write if it is one)
    logic step;    // issue one memory read and advance the scan address
    logic decide;  // settle one value bit and rewind the scan
    logic emit;    // load the result register
  } rks_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_query;  // presented item is a query
    logic in_err;    // presented query has bad positions or rank
    logic at_hi;     // scan address is at the right end of the range
    logic last_bit;  // the bit being settled is bit zero
    logic out_busy;  // result register full and stalled
  } rks_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/rks_ctrl.sv */
// Controller state machine: sequences write, scan passes and result delivery.
`default_nettype none

module rks_ctrl
  import rks_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire rks_sts_t sts_i,
  output rks_cmd_t      cmd_o
);

  rks_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.in_query) begin
            state_d = sts_i.in_err ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.at_hi) begin
          state_d = ST_DRAIN;
        end
      end
      // last read of the pass lands and is counted here
      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.last_bit ? ST_DONE : ST_SCAN;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/rks_dp.sv */
// Datapath: value memory, length register, range checks, radix select and result register.
`default_nettype none

module rks_dp
  import rks_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEN_BITS-1:0]    cfg_wdata_i,
  input  wire logic                   func_i,
  input  wire logic [POS_BITS-1:0]    left_pos_i,
  input  wire logic [POS_BITS-1:0]    right_pos_i,
  input  wire logic [OUT_BITS-1:0]    new_value_i,
  input  wire logic [LEN_BITS-1:0]    rank_k_i,
  input  wire logic                   out_stall_i,
  output logic                        out_valid_o,
  output logic [OUT_BITS-1:0]         kth_value_o,
  output logic [STATUS_BITS-1:0]      status_o,
  input  wire rks_cmd_t               cmd_i,
  output rks_sts_t                    sts_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [LEN_BITS-1:0]    length_q;
  logic [VALUE_BITS-1:0]  mem_q [DEPTH];
  logic [VALUE_BITS-1:0]  rdata_q;
  logic                   pend_q;
  logic [AW-1:0]          lo_q, hi_q, idx_q;
  logic [LEN_BITS-1:0]    k_q, zeros_q;
  logic [VALUE_BITS-1:0]  bit_q, prefix_q, decided_q;
  logic [STATUS_BITS-1:0] st_q;
  logic                   out_valid_q;
  logic [OUT_BITS-1:0]    kth_q;
  logic [STATUS_BITS-1:0] status_q;

  logic [CMP_BITS-1:0]    eff_len, len_ext, depth_c, left_ext, right_ext;
  logic [LEN_BITS-1:0]    range_size;
  logic                   pos_err, rank_err, wr_ok, match;

  // Length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      length_q <= cfg_wdata_i;
    end
  end

  // Effective length and item checks
  always_comb begin
    len_ext    = CMP_BITS'(length_q);
    depth_c    = CMP_BITS'(DEPTH);
    eff_len    = (len_ext > depth_c) ? depth_c : len_ext;
    left_ext   = CMP_BITS'(left_pos_i);
    right_ext  = CMP_BITS'(right_pos_i);
    pos_err    = (right_ext >= eff_len) || (left_pos_i > right_pos_i);
    range_size = LEN_BITS'(right_pos_i) - LEN_BITS'(left_pos_i) + LEN_BITS'(1);
    rank_err   = (rank_k_i == '0) || (rank_k_i > range_size);
    wr_ok      = (func_i == FUNC_WRITE) && (left_ext < eff_len);
  end

  // Value memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_ok) begin
      mem_q[AW'(left_pos_i)] <= VALUE_BITS'(new_value_i);
    end
    if (cmd_i.step) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.step;
    end
  end

  // An entry counts when it carries the decided prefix and a zero at the current bit
  assign match = pend_q && ((rdata_q & decided_q) == prefix_q)
                 && ((rdata_q & bit_q) == '0);

  // Radix select registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      lo_q      <= AW'(left_pos_i);
      hi_q      <= AW'(right_pos_i);
      idx_q     <= AW'(left_pos_i);
      k_q       <= rank_k_i;
      zeros_q   <= '0;
      bit_q     <= {1'b1, {(VALUE_BITS-1){1'b0}}};
      prefix_q  <= '0;
      decided_q <= '0;
      st_q      <= pos_err ? STATUS_BAD_POS : (rank_err ? STATUS_BAD_RANK : STATUS_OK);
    end else if (cmd_i.decide) begin
      if (zeros_q < k_q) begin
        k_q      <= k_q - zeros_q;
        prefix_q <= prefix_q | bit_q;
      end
      decided_q <= decided_q | bit_q;
      bit_q     <= bit_q >> 1;
      idx_q     <= lo_q;
      zeros_q   <= '0;
    end else begin
      if (cmd_i.step) begin
        idx_q <= idx_q + AW'(1);
      end
      zeros_q <= zeros_q + LEN_BITS'(match);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kth_q    <= (st_q == STATUS_OK) ? OUT_BITS'(prefix_q) : '0;
      status_q <= st_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kth_value_o = kth_q;
  assign status_o    = status_q;

  // Status to controller
  always_comb begin
    sts_o          = '0;
    sts_o.in_query = (func_i == FUNC_QUERY);
    sts_o.in_err   = pos_err || rank_err;
    sts_o.at_hi    = (idx_q == hi_q);
    sts_o.last_bit = bit_q[0];
    sts_o.out_busy = out_valid_q && out_stall_i;
  end

endmodule

`default_nettype wire

/* hw/rtl/range_kth_smallest_with_updates.sv */
// Top level of the range k-th smallest block with point writes.
//
// A write item (func 0) stores new_value at left_pos and gives no result;
// writes at or beyond the effective length (smaller of length_in_use and
// DEPTH) are dropped. A query item (func 1) returns the rank_k-th smallest
// value over positions left_pos..right_pos by radix selection, one pass over
// the range per value bit from the top down. All reads go through the single
// read port of the value memory, one entry per cycle; a query with bad
// positions or rank skips the scan and goes straight to the result. The next
// item is taken once the current one has reached the result register, even
// while that result still waits on out_stall_i. Querying a position never
// written since reset gives an unspecified value.
`default_nettype none

module range_kth_smallest_with_updates
  import rks_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [LEN_BITS-1:0]    cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   func_i,
  input  wire logic [POS_BITS-1:0]    left_pos_i,
  input  wire logic [POS_BITS-1:0]    right_pos_i,
  input  wire logic [OUT_BITS-1:0]    new_value_i,
  input  wire logic [LEN_BITS-1:0]    rank_k_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [OUT_BITS-1:0]         kth_value_o,
  output logic [STATUS_BITS-1:0]      status_o
);

  rks_cmd_t cmd;
  rks_sts_t sts;

  rks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rks_dp #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (func_i),
    .left_pos_i  (left_pos_i),
    .right_pos_i (right_pos_i),
    .new_value_i (new_value_i),
    .rank_k_i    (rank_k_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .kth_value_o (kth_value_o),
    .status_o    (status_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

/* hw/rtl/rks_checker.sv */
// Port-level checker for the range k-th smallest block, bound to the top level.
`default_nettype none

module rks_checker
  import rks_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   func_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [OUT_BITS-1:0]    kth_value_o,
  input wire logic [STATUS_BITS-1:0] status_o
);

  // Held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kth_value_o) && $stable(status_o))
    else $error("result item changed while stalled");

  // Error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_OK) |-> (kth_value_o == '0))
    else $error("error result with nonzero value");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == STATUS_OK) || (status_o == STATUS_BAD_POS)
                    || (status_o == STATUS_BAD_RANK))
    else $error("undefined status code");

  // An accepted query keeps the input side busy next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (func_i == FUNC_QUERY) |=> in_stall_o)
    else $error("input taken while a query is in progress");

  // A result only appears once the input side has gone busy
  a_no_result_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result item appeared without a query in progress");

endmodule

bind range_kth_smallest_with_updates rks_checker u_rks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kth_value_o (kth_value_o),
  .status_o    (status_o)
);

`default_nettype wire
